[sv/ssc_pkg.sv]
// Shared types, command codes and helpers for the servo serial command responder.
// No dependencies; used by ssc_core, ssc_reply_buf and the top level.
`default_nettype none

package ssc_pkg;

  localparam int unsigned TickW    = 14;
  localparam int unsigned MaxReply = 4;
  localparam int unsigned CntW     = $clog2(MaxReply + 1);

  // Command field, header bits 7..5
  typedef enum logic [2:0] {
    OP_POS   = 3'b100,
    OP_READ  = 3'b101,
    OP_WRITE = 3'b110,
    OP_ID    = 3'b111
  } op_e;

  // Subcommand byte of READ and WRITE frames
  typedef enum logic [7:0] {
    SUB_EEPROM = 8'h00,
    SUB_STRC   = 8'h01,
    SUB_SPD    = 8'h02,
    SUB_CUR    = 8'h03,
    SUB_TMP    = 8'h04,
    SUB_TCH    = 8'h05
  } sub_e;

  localparam logic [4:0] IdReadAll = 5'h1f;

  // Reply handed from the command core to the reply buffer
  typedef struct packed {
    logic                          load;
    logic [CntW-1:0]               cnt;
    logic [MaxReply-1:0][7:0]      data;
  } reply_t;

  // Number of data bytes that follow a header
  function automatic logic [1:0] frame_len(input logic [7:0] hdr);
    logic [1:0] len;
    case (hdr[7:5])
      OP_POS:   len = 2'd2;
      OP_READ:  len = 2'd1;
      OP_WRITE: len = 2'd2;
      default:  len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[sv/ssc_core.sv]
// Frame parser and command executor: holds the servo state and builds replies.
// Depends on ssc_pkg.
`default_nettype none

module ssc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            byte_vld_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            reply_free_i,
  output logic                 take_o,
  output ssc_pkg::reply_t      reply_o
);

  logic                          active_q, active_d;
  logic [7:0]                    hdr_q, hdr_d;
  logic [1:0]                    left_q, left_d;
  logic [7:0]                    d1_q, d1_d, d2_q, d2_d;
  logic [4:0]                    id_q, id_d;
  logic [7:0]                    strc_q, strc_d;
  logic [7:0]                    spd_q, spd_d;
  logic [7:0]                    cur_q, cur_d;
  logic [7:0]                    tmp_q, tmp_d;
  logic [7:0]                    cur_lim_q, cur_lim_d;
  logic [7:0]                    tmp_lim_q, tmp_lim_d;
  logic [ssc_pkg::TickW-1:0]     tick_q, tick_d;
  logic [ssc_pkg::TickW-1:0]     pos_q, pos_d;

  logic [1:0]                    idx;
  logic                          ends;
  logic [7:0]                    d1;
  logic [7:0]                    d2;
  logic [ssc_pkg::TickW-1:0]     tick_inc;
  logic [7:0]                    tick_hi;
  logic [7:0]                    tick_lo;

  assign idx      = ssc_pkg::frame_len(hdr_q) - left_q;
  assign ends     = active_q && (left_q == 2'd1);
  assign take_o   = byte_vld_i && (!ends || reply_free_i);
  // the frame's last byte may itself be a data byte that execute needs
  assign d1       = (idx == 2'd0) ? byte_i : d1_q;
  assign d2       = (idx == 2'd1) ? byte_i : d2_q;
  assign tick_inc = tick_q + 1'b1;
  assign tick_hi  = {1'b0, tick_inc[13:7]};
  assign tick_lo  = {1'b0, tick_inc[6:0]};

  always_comb begin
    active_d  = active_q;
    hdr_d     = hdr_q;
    left_d    = left_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    id_d      = id_q;
    strc_d    = strc_q;
    spd_d     = spd_q;
    cur_d     = cur_q;
    tmp_d     = tmp_q;
    cur_lim_d = cur_lim_q;
    tmp_lim_d = tmp_lim_q;
    tick_d    = tick_q;
    pos_d     = pos_q;
    reply_o   = '0;

    if (take_o) begin
      if (!active_q) begin
        if (byte_i[7] && ((byte_i[7:5] == ssc_pkg::OP_ID) || (byte_i[4:0] == id_q))) begin
          hdr_d    = byte_i;
          left_d   = ssc_pkg::frame_len(byte_i);
          active_d = 1'b1;
        end
      end else begin
        d1_d   = d1;
        d2_d   = d2;
        left_d = left_q - 1'b1;
        if (ends) begin
          active_d = 1'b0;
          case (hdr_q[7:5])
            ssc_pkg::OP_POS: begin
              tick_d          = tick_inc;
              pos_d           = {d1[6:0], d2[6:0]};
              reply_o.data[0] = hdr_q;
              reply_o.data[1] = tick_hi;
              reply_o.data[2] = tick_lo;
              reply_o.cnt     = ssc_pkg::CntW'(3);
            end
            ssc_pkg::OP_READ: begin
              reply_o.data[0] = {1'b0, hdr_q[6:0]};
              reply_o.data[1] = d1;
              case (d1)
                ssc_pkg::SUB_STRC: begin
                  reply_o.data[2] = strc_q;
                  reply_o.cnt     = ssc_pkg::CntW'(3);
                end
                ssc_pkg::SUB_SPD: begin
                  reply_o.data[2] = spd_q;
                  reply_o.cnt     = ssc_pkg::CntW'(3);
                end
                ssc_pkg::SUB_CUR: begin
                  reply_o.data[2] = cur_q;
                  cur_d           = cur_q + 1'b1;
                  reply_o.cnt     = ssc_pkg::CntW'(3);
                end
                ssc_pkg::SUB_TMP: begin
                  reply_o.data[2] = tmp_q;
                  tmp_d           = tmp_q + 1'b1;
                  reply_o.cnt     = ssc_pkg::CntW'(3);
                end
                ssc_pkg::SUB_TCH: begin
                  tick_d          = tick_inc;
                  reply_o.data[2] = tick_hi;
                  reply_o.data[3] = tick_lo;
                  reply_o.cnt     = ssc_pkg::CntW'(4);
                end
                default: begin
                  // EEPROM and unknown reads stay silent
                  reply_o.cnt = '0;
                end
              endcase
            end
            ssc_pkg::OP_WRITE: begin
              reply_o.data[0] = {1'b0, hdr_q[6:0]};
              reply_o.data[1] = d1;
              reply_o.data[2] = d2;
              reply_o.cnt     = ssc_pkg::CntW'(3);
              case (d1)
                ssc_pkg::SUB_STRC: strc_d    = d2;
                ssc_pkg::SUB_SPD:  spd_d     = d2;
                ssc_pkg::SUB_CUR:  cur_lim_d = d2;
                ssc_pkg::SUB_TMP:  tmp_lim_d = d2;
                default:           strc_d    = strc_q;
              endcase
            end
            default: begin
              if ((hdr_q[4:0] == ssc_pkg::IdReadAll) && (d1 == 8'h00)) begin
                reply_o.data[0] = {ssc_pkg::OP_ID, id_q};
              end else begin
                id_d            = hdr_q[4:0];
                reply_o.data[0] = hdr_q;
              end
              reply_o.cnt = ssc_pkg::CntW'(1);
            end
          endcase
          reply_o.load = (reply_o.cnt != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      hdr_q     <= '0;
      left_q    <= '0;
      d1_q      <= '0;
      d2_q      <= '0;
      id_q      <= '0;
      strc_q    <= '0;
      spd_q     <= '0;
      cur_q     <= '0;
      tmp_q     <= '0;
      cur_lim_q <= '0;
      tmp_lim_q <= '0;
      tick_q    <= '0;
      pos_q     <= '0;
    end else begin
      active_q  <= active_d;
      hdr_q     <= hdr_d;
      left_q    <= left_d;
      d1_q      <= d1_d;
      d2_q      <= d2_d;
      id_q      <= id_d;
      strc_q    <= strc_d;
      spd_q     <= spd_d;
      cur_q     <= cur_d;
      tmp_q     <= tmp_d;
      cur_lim_q <= cur_lim_d;
      tmp_lim_q <= tmp_lim_d;
      tick_q    <= tick_d;
      pos_q     <= pos_d;
    end
  end

endmodule

`default_nettype wire

[sv/ssc_reply_buf.sv]
// Reply buffer: holds up to four reply bytes and shifts them out one item a cycle while out_ready_i is high.
// Depends on ssc_pkg.
`default_nettype none

module ssc_reply_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssc_pkg::reply_t   reply_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             tx_byte_o,
  output logic                   last_byte_o
);

  logic [ssc_pkg::CntW-1:0]              cnt_q, cnt_d;
  logic [ssc_pkg::MaxReply-1:0][7:0]     data_q, data_d;
  logic                                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign tx_byte_o   = data_q[0];
  assign last_byte_o = (cnt_q == ssc_pkg::CntW'(1));
  // free when empty, or when the final byte leaves this cycle
  assign free_o      = !out_valid_o || (last_byte_o && out_ready_i);

  always_comb begin
    cnt_d  = cnt_q;
    data_d = data_q;
    if (reply_i.load) begin
      cnt_d  = reply_i.cnt;
      data_d = reply_i.data;
    end else if (pop) begin
      cnt_d  = cnt_q - 1'b1;
      data_d = {8'h00, data_q[ssc_pkg::MaxReply-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

`default_nettype wire

[sv/servo_serial_command_responder.sv]
// Servo serial command responder: top level with the receive register.
// Depends on ssc_pkg, ssc_core and ssc_reply_buf.
//
// Usage:
//   Received line bytes enter on the input channel (rx_byte_i), one item per
//   cycle while in_ready_o is high. Reply bytes leave on the output channel
//   (tx_byte_o, last_byte_o), last_byte_o marking the final byte of each
//   reply (one to four bytes). An accepted byte is held in the receive
//   register and is then parsed and executed in a single pass; the reply
//   of a frame-ending byte is loaded into the reply buffer as that byte is
//   taken, and the reply bytes follow one per cycle while out_ready_i is high.
//   Input rate is one byte per cycle while in_ready_o is high. A frame-ending
//   byte waits in the receive register while an earlier reply is still
//   draining, which backs up the input through in_ready_o; since a frame is
//   at least two bytes, the sustained rate is bounded by the drain of a long reply.
//   A stalled receiver holds the current reply byte steady.
//   Reset clears the servo id, settings, readings, tick counter and any
//   partial frame; the block is ready to accept input as soon as reset is released.
`default_nettype none

module servo_serial_command_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       tx_byte_o,
  output logic             last_byte_o
);

  logic              rx_vld_q, rx_vld_d;
  logic [7:0]        rx_byte_q;
  logic              take;
  logic              reply_free;
  ssc_pkg::reply_t   reply;

  assign in_ready_o = !rx_vld_q || take;

  always_comb begin
    rx_vld_d = rx_vld_q;
    if (in_ready_o) begin
      rx_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_vld_q <= 1'b0;
    end else begin
      rx_vld_q <= rx_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  ssc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_vld_i   (rx_vld_q),
    .byte_i       (rx_byte_q),
    .reply_free_i (reply_free),
    .take_o       (take),
    .reply_o      (reply)
  );

  ssc_reply_buf u_reply_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reply_i     (reply),
    .free_o      (reply_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

[sv/ssc_checker.sv]
// Port-level checks for the servo serial command responder, bound to the top level.
// No package dependencies.
`default_nettype none

module ssc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  tx_byte_o,
  input wire logic        last_byte_o
);

  // stalled reply item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o)
      && $stable(last_byte_o))
    else $error("reply item changed while stalled");

  // a reply keeps going until its last byte
  a_reply_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_byte_o |=> out_valid_o)
    else $error("reply cut off before its last byte");

  // output only goes idle right after a last byte
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(last_byte_o) && $past(out_ready_i))
    else $error("output went idle mid-reply");

  // last marker never shows without a valid item
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> out_valid_o)
    else $error("last marker without valid item");

endmodule

bind servo_serial_command_responder ssc_checker u_ssc_checker (.*);

`default_nettype wire

[tb/servo_serial_command_responder_tb.sv]
// Testbench for servo_serial_command_responder: directed and random byte frames with
// random idling on both sides, checked against a scoreboard that tracks the servo state.
// Depends on ssc_pkg and the servo_serial_command_responder RTL.

package ssc_tb_pkg;
  import ssc_pkg::*;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } reply_byte_t;

  class ssc_scoreboard;
    // servo state as seen from the line
    bit          framing;
    logic [7:0]  hdr;
    logic [1:0]  left;
    logic [7:0]  dat [3];
    logic [4:0]  id;
    logic [7:0]  stretch;
    logic [7:0]  speed;
    logic [7:0]  cur_rd;
    logic [7:0]  tmp_rd;
    logic [7:0]  cur_lim;
    logic [7:0]  tmp_lim;
    logic [13:0] ticks;
    logic [13:0] pos;
    reply_byte_t pending_replies [$];
    int          mismatches;

    function new();
      framing    = 1'b0;
      hdr        = '0;
      left       = '0;
      dat        = '{default: '0};
      id         = '0;
      stretch    = '0;
      speed      = '0;
      cur_rd     = '0;
      tmp_rd     = '0;
      cur_lim    = '0;
      tmp_lim    = '0;
      ticks      = '0;
      pos        = '0;
      mismatches = 0;
    endfunction

    // data bytes that follow a header of this command
    function int data_count(input logic [7:0] h);
      case (h[7:5])
        OP_POS:   return 2;
        OP_READ:  return 1;
        OP_WRITE: return 2;
        default:  return 3;
      endcase
    endfunction

    function void flag(input string what, input reply_byte_t want, input reply_byte_t got);
      if (mismatches < 10)
        $display("%0t: %s: expected tx %02h last %0b, got tx %02h last %0b",
                 $realtime, what, want.tx, want.last, got.tx, got.last);
      mismatches++;
    endfunction

    function void note_rx(input logic [7:0] b);
      logic [7:0] r [4];
      int         n;
      n = 0;
      if (!framing) begin
        // an idle byte only opens a frame if it is a header for us or an ID command
        if (b[7] && (b[7:5] == OP_ID || b[4:0] == id)) begin
          hdr     = b;
          left    = 2'(data_count(b));
          framing = 1'b1;
        end
        return;
      end
      // inside a frame every byte is data, bit 7 or not
      dat[data_count(hdr) - int'(left)] = b;
      left = left - 2'd1;
      if (left != 2'd0) return;
      framing = 1'b0;
      case (hdr[7:5])
        OP_POS: begin
          ticks = ticks + 14'd1;
          pos   = {dat[0][6:0], dat[1][6:0]};
          r[0]  = hdr;
          r[1]  = {1'b0, ticks[13:7]};
          r[2]  = {1'b0, ticks[6:0]};
          n     = 3;
        end
        OP_READ: begin
          r[0] = {1'b0, hdr[6:0]};
          r[1] = dat[0];
          case (dat[0])
            SUB_STRC: begin
              r[2] = stretch;
              n    = 3;
            end
            SUB_SPD: begin
              r[2] = speed;
              n    = 3;
            end
            SUB_CUR: begin
              r[2]   = cur_rd;
              cur_rd = cur_rd + 8'd1;
              n      = 3;
            end
            SUB_TMP: begin
              r[2]   = tmp_rd;
              tmp_rd = tmp_rd + 8'd1;
              n      = 3;
            end
            SUB_TCH: begin
              ticks = ticks + 14'd1;
              r[2]  = {1'b0, ticks[13:7]};
              r[3]  = {1'b0, ticks[6:0]};
              n     = 4;
            end
            default: n = 0;  // EEPROM and unknown reads stay silent
          endcase
        end
        OP_WRITE: begin
          r[0] = {1'b0, hdr[6:0]};
          r[1] = dat[0];
          r[2] = dat[1];
          n    = 3;
          case (dat[0])
            SUB_STRC: stretch = dat[1];
            SUB_SPD:  speed   = dat[1];
            SUB_CUR:  cur_lim = dat[1];
            SUB_TMP:  tmp_lim = dat[1];
            default: ;
          endcase
        end
        default: begin
          if (hdr[4:0] == IdReadAll && dat[0] == 8'h00) begin
            r[0] = {OP_ID, id};
          end else begin
            id   = hdr[4:0];
            r[0] = hdr;
          end
          n = 1;
        end
      endcase
      for (int k = 0; k < n; k++) pending_replies.push_back('{r[k], k == n - 1});
    endfunction

    function void check_tx(input logic [7:0] b, input logic last);
      reply_byte_t got;
      reply_byte_t want;
      got = '{b, last};
      if (pending_replies.size() == 0) begin
        flag("unexpected reply byte", '0, got);
        return;
      end
      want = pending_replies.pop_front();
      if (got.tx !== want.tx || got.last !== want.last) flag("reply byte mismatch", want, got);
    endfunction
  endclass
endpackage

module servo_serial_command_responder_tb;
  import ssc_pkg::*;
  import ssc_tb_pkg::*;

  localparam int RxItems  = 110;
  localparam int CalmFrom = 85;
  localparam int LongHold = 60;
  localparam int Drain    = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] tx_byte_o;
  logic       last_byte_o;

  ssc_scoreboard sb = new();
  int            n_sent = 0;
  bit            calm = 1'b0;
  bit            long_hold = 1'b0;

  servo_serial_command_responder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("servo_serial_command_responder_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_tx(tx_byte_o, last_byte_o);
  end

  // receiver: random stall bursts, one long hold-off on request, none once calm
  initial begin : tx_side
    @(posedge clk_i iff rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  task automatic send_rx(input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_rx(b);
    n_sent++;
  endtask

  task automatic send_random_frame();
    logic [2:0] op;
    logic [7:0] h;
    logic [7:0] d;
    int         nd;
    if ($urandom_range(0, 9) == 0) begin
      send_rx(8'($urandom));  // stray byte
      return;
    end
    op = 3'($urandom_range(4, 7));
    h  = {op, sb.id};
    if (op == OP_ID)
      h[4:0] = ($urandom_range(0, 3) == 0) ? IdReadAll : 5'($urandom_range(0, 31));
    nd = sb.data_count(h);
    send_rx(h);
    for (int k = 0; k < nd; k++) begin
      d = 8'($urandom);
      if (k == 0 && (op == OP_READ || op == OP_WRITE) && $urandom_range(0, 7) != 0)
        d = 8'($urandom_range(0, 5));
      else if (k == 0 && op == OP_ID && $urandom_range(0, 1) == 0)
        d = 8'h00;
      send_rx(d);
    end
  endtask

  initial begin : rx_side
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_rx(8'h12);                      // idle byte without bit 7
    send_rx({OP_POS, 5'd5});             // header for another servo
    send_rx({OP_POS, 5'd0});
    send_rx(8'hff);
    send_rx(8'hff);
    send_rx({OP_WRITE, 5'd0});
    send_rx(SUB_STRC);
    send_rx(8'hff);
    send_rx({OP_READ, 5'd0});
    send_rx(SUB_STRC);
    send_rx({OP_READ, 5'd0});
    send_rx(SUB_TCH);
    send_rx({OP_READ, 5'd0});
    send_rx(SUB_CUR);
    send_rx({OP_ID, 5'd3});              // id write, data with bit 7 set
    send_rx(8'h7f);
    send_rx(8'h80);
    send_rx(8'h00);
    send_rx({OP_READ, 5'd3});
    send_rx(SUB_EEPROM);                 // silent read
    send_rx({OP_ID, IdReadAll});         // id query
    send_rx(8'h00);
    send_rx(8'h12);
    send_rx(8'h34);
    send_rx({OP_WRITE, 5'd3});
    send_rx(8'hff);                      // unknown subcommand, still echoed
    send_rx(8'h00);

    long_hold = 1'b1;
    while (n_sent < RxItems) begin
      if (n_sent >= CalmFrom) calm = 1'b1;
      send_random_frame();
    end
    in_valid_i <= 1'b0;
    calm = 1'b1;

    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("servo_serial_command_responder_tb passed");
    end else begin
      $display("servo_serial_command_responder_tb failed");
    end
    $finish;
  end
endmodule
